// ===== design/tlvd_pkg.sv =====
// Shared types and constants for the subrecord type-length-value deframer.
// Holds the input and result word structs, item kinds and status codes.
// No dependencies.
`default_nettype none

package tlvd_pkg;

    // Input word: one payload byte plus its end mark
    typedef struct packed {
        logic [7:0] payload_byte;
        logic       payload_end;
    } tlv_in_t;

    // Result word
    typedef struct packed {
        logic [1:0]  item_kind;
        logic [31:0] sub_type;
        logic [7:0]  data_out;
        logic        first_of_sub;
        logic        last_of_sub;
        logic [1:0]  status;
        logic        last_result;
    } tlv_out_t;

    localparam logic [1:0] KIND_DATA   = 2'd0;
    localparam logic [1:0] KIND_EMPTY  = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    // Status codes double as the sticky error codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_XXXX = 2'd1;
    localparam logic [1:0] ST_TRUNC    = 2'd2;

    localparam logic [31:0] MARKER_XXXX  = 32'h5858_5858;
    localparam logic [15:0] XVALUE_BYTES = 16'd4;
    localparam logic [3:0]  HDR_BYTES    = 4'd6;

    // Result queue
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

endpackage : tlvd_pkg

`default_nettype wire

// ===== design/subrecord_tlv_deframer.sv =====
// Top level of the subrecord type-length-value deframer.
// Parses header, XXXX override and data bytes and queues result words.
// Depends on tlvd_pkg.
//
//  channel  | dir | handshake                      | word
//  ---------+-----+--------------------------------+---------------------
//  payload  | in  | payload_valid / payload_stall  | tlvd_pkg::tlv_in_t
//  result   | out | result_valid  / result_stall   | tlvd_pkg::tlv_out_t
//
// One payload byte is taken per cycle while payload_stall is low; its
// results land in a 4-word result queue on the same edge and leave at one
// word per cycle while result_stall is low. A byte that yields two words
// (data or empty event followed by the end status) fills two queue slots;
// payload_stall rises when the queue holds three or more words.
// rst_n is asynchronous and clears parser state and queue pointers.
// result_stall only backs up the queue; parsing resumes below three words.
`default_nettype none

module subrecord_tlv_deframer (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              payload_valid,
    output logic                   payload_stall,
    input  wire tlvd_pkg::tlv_in_t payload,
    output logic                   result_valid,
    input  wire logic              result_stall,
    output tlvd_pkg::tlv_out_t     result
);

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_XVALUE = 2'd1;
    localparam logic [1:0] PH_DATA   = 2'd2;

    localparam int unsigned AW = tlvd_pkg::FIFO_AW;
    localparam int unsigned CW = tlvd_pkg::FIFO_AW + 1;

    // Parser state
    logic [1:0]  phase_reg,      phase_next;
    logic [2:0]  byte_index_reg, byte_index_next;
    logic [31:0] type_reg,       type_next;
    logic [15:0] size_low_reg,   size_low_next;
    logic [31:0] pending_reg,    pending_next;
    logic [31:0] bytes_left_reg, bytes_left_next;
    logic [1:0]  error_code_reg, error_code_next;

    // Result queue
    tlvd_pkg::tlv_out_t fifo_mem [tlvd_pkg::FIFO_DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg,  count_next;

    logic               accept;
    logic               pop;
    logic [1:0]         push_cnt;
    tlvd_pkg::tlv_out_t res_a;
    tlvd_pkg::tlv_out_t res_b;
    tlvd_pkg::tlv_out_t prim;
    tlvd_pkg::tlv_out_t stat;
    logic               prim_vld;
    logic [3:0]         idx_inc;
    logic [31:0]        size_sel;
    logic               last_byte;

    assign payload_stall = (count_reg > CW'(tlvd_pkg::FIFO_DEPTH - 2));
    assign accept        = payload_valid && !payload_stall;
    assign result_valid  = (count_reg != '0);
    assign pop           = result_valid && !result_stall;
    assign result        = fifo_mem[rd_ptr_reg];

    always_comb
    begin
        phase_next      = phase_reg;
        byte_index_next = byte_index_reg;
        type_next       = type_reg;
        size_low_next   = size_low_reg;
        pending_next    = pending_reg;
        bytes_left_next = bytes_left_reg;
        error_code_next = error_code_reg;
        prim            = '0;
        prim_vld        = 1'b0;
        stat            = '0;
        res_a           = '0;
        res_b           = '0;
        push_cnt        = 2'd0;
        idx_inc         = {1'b0, byte_index_reg} + 4'd1;
        size_sel        = '0;
        last_byte       = 1'b0;

        if (accept)
        begin
            if (error_code_reg == tlvd_pkg::ST_OK)
            begin
                case (phase_reg)
                    PH_XVALUE:
                    begin
                        // gather the override value little-endian
                        bytes_left_next = bytes_left_reg
                            | (32'(payload.payload_byte) << {byte_index_reg[1:0], 3'b000});
                        if (byte_index_reg[1:0] == 2'd3)
                        begin
                            pending_next    = bytes_left_next;
                            bytes_left_next = '0;
                            byte_index_next = '0;
                            phase_next      = PH_HEADER;
                        end
                        else
                        begin
                            byte_index_next = idx_inc[2:0];
                        end
                    end
                    PH_DATA:
                    begin
                        last_byte          = (bytes_left_reg <= 32'd1);
                        prim_vld           = 1'b1;
                        prim.item_kind     = tlvd_pkg::KIND_DATA;
                        prim.sub_type      = type_reg;
                        prim.data_out      = payload.payload_byte;
                        prim.first_of_sub  = (byte_index_reg == 3'd0);
                        prim.last_of_sub   = last_byte;
                        if (last_byte)
                        begin
                            bytes_left_next = '0;
                            byte_index_next = '0;
                            phase_next      = PH_HEADER;
                        end
                        else
                        begin
                            bytes_left_next = bytes_left_reg - 32'd1;
                            byte_index_next = 3'd1;
                        end
                    end
                    default:
                    begin
                        // header phase; the unused code behaves the same
                        if (byte_index_reg == 3'd0)
                        begin
                            type_next     = {24'b0, payload.payload_byte};
                            size_low_next = '0;
                        end
                        else if (byte_index_reg < 3'd4)
                        begin
                            type_next = type_reg
                                | (32'(payload.payload_byte) << {byte_index_reg[1:0], 3'b000});
                        end
                        else if (byte_index_reg == 3'd4)
                        begin
                            size_low_next = size_low_reg | {8'b0, payload.payload_byte};
                        end
                        else if (byte_index_reg == 3'd5)
                        begin
                            size_low_next = size_low_reg | {payload.payload_byte, 8'b0};
                        end
                        byte_index_next = idx_inc[2:0];
                        phase_next      = PH_HEADER;
                        if (idx_inc >= tlvd_pkg::HDR_BYTES)
                        begin
                            byte_index_next = '0;
                            if (type_next == tlvd_pkg::MARKER_XXXX)
                            begin
                                if (size_low_next != tlvd_pkg::XVALUE_BYTES)
                                begin
                                    error_code_next = tlvd_pkg::ST_BAD_XXXX;
                                end
                                else
                                begin
                                    bytes_left_next = '0;
                                    phase_next      = PH_XVALUE;
                                end
                            end
                            else
                            begin
                                size_sel     = (pending_reg != '0) ? pending_reg
                                                                   : {16'b0, size_low_next};
                                pending_next = '0;
                                if (size_sel == '0)
                                begin
                                    prim_vld       = 1'b1;
                                    prim.item_kind = tlvd_pkg::KIND_EMPTY;
                                    prim.sub_type  = type_next;
                                end
                                else
                                begin
                                    bytes_left_next = size_sel;
                                    phase_next      = PH_DATA;
                                end
                            end
                        end
                    end
                endcase
            end

            if (payload.payload_end)
            begin
                stat.item_kind   = tlvd_pkg::KIND_STATUS;
                stat.last_result = 1'b1;
                stat.status      = error_code_next;
                if (error_code_next == tlvd_pkg::ST_OK
                    && !((phase_next == PH_HEADER || phase_next == 2'd3)
                         && byte_index_next == 3'd0))
                begin
                    stat.status = tlvd_pkg::ST_TRUNC;
                end
                // start the next payload clean
                phase_next      = PH_HEADER;
                byte_index_next = '0;
                type_next       = '0;
                size_low_next   = '0;
                pending_next    = '0;
                bytes_left_next = '0;
                error_code_next = tlvd_pkg::ST_OK;
            end

            if (prim_vld && payload.payload_end)
            begin
                res_a    = prim;
                res_b    = stat;
                push_cnt = 2'd2;
            end
            else if (prim_vld)
            begin
                res_a             = prim;
                res_a.last_result = 1'b1;
                push_cnt          = 2'd1;
            end
            else if (payload.payload_end)
            begin
                res_a    = stat;
                push_cnt = 2'd1;
            end
        end
    end

    assign wr_ptr_next = wr_ptr_reg + AW'(push_cnt);
    assign rd_ptr_next = rd_ptr_reg + AW'(pop);
    assign count_next  = count_reg + CW'(push_cnt) - CW'(pop);

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            fifo_mem[wr_ptr_reg] <= res_a;
        end
        if (push_cnt == 2'd2)
        begin
            fifo_mem[wr_ptr_reg + AW'(1)] <= res_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HEADER;
            byte_index_reg <= '0;
            type_reg       <= '0;
            size_low_reg   <= '0;
            pending_reg    <= '0;
            bytes_left_reg <= '0;
            error_code_reg <= tlvd_pkg::ST_OK;
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            count_reg      <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            byte_index_reg <= byte_index_next;
            type_reg       <= type_next;
            size_low_reg   <= size_low_next;
            pending_reg    <= pending_next;
            bytes_left_reg <= bytes_left_next;
            error_code_reg <= error_code_next;
            wr_ptr_reg     <= wr_ptr_next;
            rd_ptr_reg     <= rd_ptr_next;
            count_reg      <= count_next;
        end
    end

    // Queue never overfills
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(tlvd_pkg::FIFO_DEPTH))
        else $error("result queue over capacity");

    // End of payload always returns the parser to its start state
    a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
        accept && payload.payload_end
        |=> phase_reg == PH_HEADER && byte_index_reg == 3'd0
            && error_code_reg == tlvd_pkg::ST_OK && pending_reg == '0)
        else $error("parser not reset after payload end");

    // Error is sticky until payload end
    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        error_code_reg != tlvd_pkg::ST_OK && !(accept && payload.payload_end)
        |=> $stable(error_code_reg) && $stable(phase_reg))
        else $error("state moved after error");

    // Data phase always owes at least one byte
    a_data_owed: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DATA |-> bytes_left_reg != '0)
        else $error("data phase with nothing left");

    // Header position stays inside the six header bytes
    a_hdr_index: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_HEADER |-> byte_index_reg < 3'd6)
        else $error("header index out of range");

endmodule : subrecord_tlv_deframer

`default_nettype wire
